>>> sv/tpd_pkg.sv
// shared types and constants for the text packet deframer
package tpd_pkg;

  localparam int LEN_W = 7;

  localparam logic [7:0] CH_START = 8'h40;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_READ = 2'd1,
    CMD_POLL = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_PAYLOAD  = 2'd1,
    PH_AWAIT_LF = 2'd2
  } phase_t;

  typedef struct packed {
    logic wr_en;
    logic ready_cur;
    logic ready_nxt;
    logic ovf_nxt;
  } tpd_frm_st_t;

endpackage

>>> sv/tpd_frame.sv
// frame phase tracking, write position, length latch and status flags
module tpd_frame import tpd_pkg::*; #(
  parameter int BUFFER_DEPTH = 64,
  parameter int PW = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take_byte,
  input  logic          poll_clr,
  input  logic [7:0]    rx_byte,
  output logic [PW-1:0] wr_pos,
  output logic [PW-1:0] len_nxt,
  output tpd_frm_st_t   st
);

  phase_t        phase_r, phase_nxt;
  logic [PW-1:0] wr_pos_r, wr_pos_nxt;
  logic [PW-1:0] len_r;
  logic          ready_r, ready_nxt;
  logic          ovf_r, ovf_nxt;
  logic          room;
  logic          wr_en, set_ovf, latch, start;

  assign room = (32'(wr_pos_r) < BUFFER_DEPTH);

  always_comb begin
    phase_nxt = phase_r;
    if (take_byte) begin
      case (phase_r)
        PH_PAYLOAD: begin
          if (rx_byte == CH_CR) phase_nxt = PH_AWAIT_LF;
        end
        PH_AWAIT_LF: begin
          if (rx_byte == CH_LF) phase_nxt = PH_HUNT;
        end
        default: begin
          if (rx_byte == CH_START) phase_nxt = PH_PAYLOAD;
        end
      endcase
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    set_ovf = 1'b0;
    latch   = 1'b0;
    start   = 1'b0;
    if (take_byte) begin
      case (phase_r)
        PH_PAYLOAD: begin
          if (rx_byte != CH_CR) begin
            wr_en   = room;
            set_ovf = !room;
          end
        end
        PH_AWAIT_LF: begin
          latch = (rx_byte == CH_LF);
        end
        default: begin
          start = (rx_byte == CH_START);
        end
      endcase
    end
  end

  always_comb begin
    wr_pos_nxt = wr_pos_r;
    if (start) wr_pos_nxt = '0;
    else if (wr_en) wr_pos_nxt = wr_pos_r + PW'(1);
    ovf_nxt = start ? 1'b0 : (set_ovf ? 1'b1 : ovf_r);
    len_nxt = latch ? wr_pos_r : len_r;
    ready_nxt = latch ? 1'b1 : (poll_clr ? 1'b0 : ready_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      wr_pos_r <= '0;
      len_r    <= '0;
      ready_r  <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      wr_pos_r <= wr_pos_nxt;
      len_r    <= len_nxt;
      ready_r  <= ready_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign wr_pos       = wr_pos_r;
  assign st.wr_en     = wr_en;
  assign st.ready_cur = ready_r;
  assign st.ready_nxt = ready_nxt;
  assign st.ovf_nxt   = ovf_nxt;

endmodule

>>> sv/text_packet_deframer.sv
// text packet deframer top level: payload buffer and result pipeline
// Takes one request per clock unless out_stall holds the output: a received
// byte, a read of a stored payload byte, a poll that returns and clears the
// packet ready flag, or a no-op. Frames open with '@' and close with CR then
// LF; payload bytes go into a BUFFER_DEPTH byte buffer and bytes beyond it
// are dropped and raise overflow. Each request gives one result: the holding
// stage registers the state update and the buffer read, then the output register
// presents it; the holding stage takes one more request while a result waits.
module text_packet_deframer import tpd_pkg::*; #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_command,
  input  logic [7:0]       in_rx_byte,
  input  logic [5:0]       in_read_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_read_data,
  output logic             out_packet_ready,
  output logic [LEN_W-1:0] out_packet_length,
  output logic             out_overflow
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = $clog2(BUFFER_DEPTH + 1);

  logic [7:0]       mem [BUFFER_DEPTH];
  logic [7:0]       rdata_r;

  logic             in_acc;
  cmd_t             cmd;
  logic             take_byte, poll_clr;
  logic [PW-1:0]    wr_pos, len_nxt;
  tpd_frm_st_t      frm_st;
  logic [AW-1:0]    rd_addr;
  logic             rd_ok;

  logic             s1_valid_r;
  logic             s1_rd_en_r;
  logic             s1_ready_r;
  logic [LEN_W-1:0] s1_len_r;
  logic             s1_ovf_r;
  logic             s1_move;

  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic             out_ready_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_ovf_r;

  assign cmd       = cmd_t'(in_command);
  assign s1_move   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_acc    = in_valid && !in_stall;
  assign take_byte = in_acc && (cmd == CMD_BYTE);
  assign poll_clr  = in_acc && (cmd == CMD_POLL);
  assign rd_ok     = (cmd == CMD_READ) && (32'(in_read_index) < BUFFER_DEPTH);
  assign rd_addr   = AW'(in_read_index);

  tpd_frame #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .PW(PW)
  ) u_frame (
    .clk(clk),
    .rst_n(rst_n),
    .take_byte(take_byte),
    .poll_clr(poll_clr),
    .rx_byte(in_rx_byte),
    .wr_pos(wr_pos),
    .len_nxt(len_nxt),
    .st(frm_st)
  );

  always_ff @(posedge clk) begin
    if (frm_st.wr_en) mem[wr_pos[AW-1:0]] <= in_rx_byte;
    if (in_acc) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rd_en_r <= rd_ok;
      s1_ready_r <= (cmd == CMD_BYTE) ? frm_st.ready_nxt : frm_st.ready_cur;
      s1_len_r   <= LEN_W'(len_nxt);
      s1_ovf_r   <= frm_st.ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r  <= s1_rd_en_r ? rdata_r : 8'd0;
      out_ready_r <= s1_ready_r;
      out_len_r   <= s1_len_r;
      out_ovf_r   <= s1_ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_data_r;
  assign out_packet_ready  = out_ready_r;
  assign out_packet_length = out_len_r;
  assign out_overflow      = out_ovf_r;

`ifndef SYNTHESIS
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty holding stage");

  a_held_request_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r)
    else $error("held request lost while output stalled");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    frm_st.wr_en |-> (take_byte && (32'(wr_pos) < BUFFER_DEPTH)))
    else $error("buffer write outside a byte request or past capacity");

  a_out_follows_move: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("moved request did not reach output");
`endif

endmodule
